// ===== rtl/core/pcf_pkg.sv =====
`default_nettype none

package pcf_pkg;

   localparam int SAMPLE_W         = 32;
   localparam int WORD_W           = 16;
   localparam int HIFI_W           = 1;
   localparam int LAYOUT_W         = 2;
   localparam int CHANNEL_COUNT_W  = 4;
   localparam int OFFSET_W         = 3;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 4;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF  = 2;

   // positions reordered to USB channel order when the frame is wide enough
   localparam int USB_ORDER_LEN    = 8;
   localparam logic [2:0] USB_ORDER [USB_ORDER_LEN] = '{
      3'd0, 3'd1, 3'd6, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIFI_MODE      = 2'd0,
      CSR_LAYOUT         = 2'd1,
      CSR_CHANNEL_COUNT  = 2'd2,
      CSR_CHANNEL_OFFSET = 2'd3
   } csr_index_type;

   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_MONO   = 2'd0,
      LAYOUT_STEREO = 2'd1,
      LAYOUT_MULTI  = 2'd2
   } layout_type;

   localparam logic [LAYOUT_W-1:0]        LAYOUT_RESET        = LAYOUT_STEREO;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

endpackage

`default_nettype wire

// ===== rtl/core/pcm_channel_formatter_unit.sv =====
`default_nettype none

// Channel  | Direction | Ports
// ---------+-----------+------------------------------------------------------
// req      | in        | req_valid, req_stall, req_mix_sample[31:0] (signed)
// rsp      | out       | rsp_valid, rsp_stall, rsp_out_word[15:0], rsp_run_last
// csr      | in        | csr_write_enable, csr_index[1:0], csr_write_data[3:0]
//
// A req transaction is taken in any cycle the frame queue has room; a full
// frame or pair becomes one queue entry.
// The back end drives one rsp transaction per cycle while rsp_stall is low,
// and the front keeps taking samples into the queue meanwhile; that output
// stage sets the sustained rate.
// Reset is synchronous; config returns to stereo, two channels, 16-bit.
// req stalls only while the queue is full; rsp stall holds the current word.

module pcm_channel_formatter_unit #(
   parameter int MaxChannels = pcf_pkg::MAX_CHANNELS_DEF,
   parameter int QueueDepth  = pcf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [pcf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pcf_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [pcf_pkg::SAMPLE_W-1:0] req_mix_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pcf_pkg::WORD_W-1:0]               rsp_out_word,
   output logic                                     rsp_run_last
);

   import pcf_pkg::*;

   // count must hold MaxChannels itself
   localparam int CountW = $clog2(MaxChannels + 1);
   localparam int DescW  = CountW + MaxChannels * WORD_W;

   logic                               queue_full;
   logic                               queue_valid;
   logic                               push;
   logic                               pop;
   logic [MaxChannels-1:0][WORD_W-1:0] desc_words;
   logic [CountW-1:0]                  desc_count;
   logic [DescW-1:0]                   push_data;
   logic [DescW-1:0]                   pop_data;
   logic [MaxChannels-1:0][WORD_W-1:0] queue_words;
   logic [CountW-1:0]                  queue_count;

   assign req_stall   = queue_full;
   assign push_data   = {desc_count, desc_words};
   assign queue_words = pop_data[MaxChannels*WORD_W-1:0];
   assign queue_count = pop_data[DescW-1:MaxChannels*WORD_W];

   // front: config registers, sample formatting, pair/frame gathering
   pcf_front #(
      .MaxChannels(MaxChannels),
      .CountW     (CountW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_mix_sample  (req_mix_sample),
      .queue_full      (queue_full),
      .push            (push),
      .desc_words      (desc_words),
      .desc_count      (desc_count)
   );

   // frame descriptors waiting for the output stage
   pcf_queue #(
      .Width(DescW),
      .Depth(QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (queue_full),
      .pop      (pop),
      .valid    (queue_valid),
      .pop_data (pop_data)
   );

   // back: walks a frame one word per transaction
   pcf_back #(
      .MaxChannels(MaxChannels),
      .CountW     (CountW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_words (queue_words),
      .queue_count (queue_count),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_word(rsp_out_word),
      .rsp_run_last(rsp_run_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/pcf_queue.sv =====
`default_nettype none

module pcf_queue #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [Width-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [Width-1:0]      pop_data
);

   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int NW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;

   assign full     = (fill_ff == NW'(Depth));
   assign valid    = (fill_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcf_front.sv =====
`default_nettype none

module pcf_front #(
   parameter int MaxChannels = 8,
   parameter int CountW      = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pcf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pcf_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  wire logic                                 req_valid,
   input  wire logic signed [pcf_pkg::SAMPLE_W-1:0]  req_mix_sample,
   input  wire logic                                 queue_full,
   output logic                                      push,
   output logic [MaxChannels-1:0][pcf_pkg::WORD_W-1:0] desc_words,
   output logic [CountW-1:0]                         desc_count
);

   import pcf_pkg::*;

   localparam int IW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

   logic [HIFI_W-1:0]          hifi_ff, hifi_in;
   logic [LAYOUT_W-1:0]        layout_ff, layout_in;
   logic [CHANNEL_COUNT_W-1:0] count_ff, count_in;
   logic [OFFSET_W-1:0]        offset_ff, offset_in;
   logic [CountW-1:0]          slot_ff, slot_in;
   logic [WORD_W-1:0]          held_left_ff;
   logic [WORD_W-1:0]          store_ff [MaxChannels];

   logic                       accept;
   logic [WORD_W-1:0]          kept;
   logic [WORD_W-1:0]          word;
   logic [CountW-1:0]          nch;
   logic [CountW-1:0]          off;
   logic [CountW-1:0]          slot_eff;
   logic [CountW-1:0]          slot_next;
   logic                       frame_done;
   logic [WORD_W-1:0]          pair_left;
   logic [WORD_W-1:0]          pair_right;
   logic [WORD_W-1:0]          cur [MaxChannels];

   assign accept = req_valid && !queue_full;

   // keep 16 bits and swap bytes
   assign kept = hifi_ff[0] ? req_mix_sample[31:16] : req_mix_sample[15:0];
   assign word = {kept[7:0], kept[15:8]};

   always_comb begin
      if (count_ff == '0) begin
         nch = CountW'(1);
      end else if (int'(count_ff) > MaxChannels) begin
         nch = CountW'(MaxChannels);
      end else begin
         nch = CountW'(count_ff);
      end
   end

   // stereo offset clamped to the last pair position
   always_comb begin
      if (int'(offset_ff) > int'(nch) - 2) begin
         off = nch - CountW'(2);
      end else begin
         off = CountW'(offset_ff);
      end
   end

   assign slot_eff   = (slot_ff >= nch) ? '0 : slot_ff;
   assign slot_next  = slot_eff + CountW'(1);
   assign frame_done = (slot_next == nch);

   always_comb begin
      for (int s = 0; s < MaxChannels; s++) begin
         cur[s] = (slot_eff == CountW'(s)) ? word : store_ff[s];
      end
   end

   always_comb begin
      if (layout_ff == LAYOUT_MONO) begin
         pair_left  = word;
         pair_right = word;
      end else begin
         pair_left  = held_left_ff;
         pair_right = word;
      end
   end

   // descriptor build and push decision
   always_comb begin
      push       = 1'b0;
      desc_words = '0;
      desc_count = nch;
      case (layout_ff)
         LAYOUT_MONO, LAYOUT_STEREO: begin
            push = accept && ((layout_ff == LAYOUT_MONO) || slot_ff[0]);
            if ((layout_ff == LAYOUT_MONO) && (nch < CountW'(2))) begin
               desc_words[0] = word;
               desc_count    = CountW'(1);
            end else if (nch <= CountW'(2)) begin
               desc_words[0] = pair_left;
               desc_words[1] = pair_right;
               desc_count    = CountW'(2);
            end else begin
               for (int c = 0; c < MaxChannels; c++) begin
                  if (CountW'(c) == off) begin
                     desc_words[c] = pair_left;
                  end else if (CountW'(c) == off + CountW'(1)) begin
                     desc_words[c] = pair_right;
                  end
               end
            end
         end
         default: begin
            push = accept && frame_done;
            for (int c = 0; c < MaxChannels; c++) begin
               if ((int'(nch) >= USB_ORDER_LEN) && (c < USB_ORDER_LEN)) begin
                  desc_words[c] = cur[IW'(USB_ORDER[c])];
               end else begin
                  desc_words[c] = cur[c];
               end
            end
         end
      endcase
   end

   always_comb begin
      hifi_in   = hifi_ff;
      layout_in = layout_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      slot_in   = slot_ff;
      if (accept) begin
         case (layout_ff)
            LAYOUT_MONO:   slot_in = slot_ff;
            LAYOUT_STEREO: slot_in = slot_ff[0] ? '0 : CountW'(1);
            default:       slot_in = frame_done ? '0 : slot_next;
         endcase
      end
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HIFI_MODE:      hifi_in = csr_write_data[HIFI_W-1:0];
            CSR_LAYOUT: begin
               layout_in = csr_write_data[LAYOUT_W-1:0];
               slot_in   = '0;
            end
            CSR_CHANNEL_COUNT: begin
               count_in = csr_write_data[CHANNEL_COUNT_W-1:0];
               slot_in  = '0;
            end
            CSR_CHANNEL_OFFSET: offset_in = csr_write_data[OFFSET_W-1:0];
            default:            hifi_in = hifi_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hifi_ff   <= '0;
         layout_ff <= LAYOUT_RESET;
         count_ff  <= CHANNEL_COUNT_RESET;
         offset_ff <= '0;
         slot_ff   <= '0;
      end else begin
         hifi_ff   <= hifi_in;
         layout_ff <= layout_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (layout_ff == LAYOUT_STEREO) && !slot_ff[0]) begin
         held_left_ff <= word;
      end
      if (accept && layout_ff[1]) begin
         store_ff[slot_eff[IW-1:0]] <= word;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pcf_back.sv =====
`default_nettype none

module pcf_back #(
   parameter int MaxChannels = 8,
   parameter int CountW      = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   queue_valid,
   input  wire logic [MaxChannels-1:0][pcf_pkg::WORD_W-1:0] queue_words,
   input  wire logic [CountW-1:0]                      queue_count,
   output logic                                        pop,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [pcf_pkg::WORD_W-1:0]                  rsp_out_word,
   output logic                                        rsp_run_last
);

   import pcf_pkg::*;

   localparam int IW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

   logic                                   busy_ff, busy_in;
   logic [IW-1:0]                          idx_ff, idx_in;
   logic [CountW-1:0]                      count_ff;
   logic [MaxChannels-1:0][WORD_W-1:0]     words_ff;
   logic                                   advance;

   assign rsp_valid    = busy_ff;
   assign rsp_out_word = words_ff[idx_ff];
   assign rsp_run_last = (CountW'(idx_ff) == count_ff - CountW'(1));

   assign advance = busy_ff && !rsp_stall;
   // refill as the last word leaves, so frames follow without a gap
   assign pop     = queue_valid && (!busy_ff || (advance && rsp_run_last));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (advance) begin
         if (rsp_run_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         words_ff <= queue_words;
         count_ff <= queue_count;
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/pcm_channel_formatter_unit_tb.sv =====
module pcm_channel_formatter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcf_pkg::*;

   localparam int MAX_CH        = MAX_CHANNELS_DEF;
   // quiet cycles after the last word before touching config or ending the run
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 330;
   localparam int TAIL_ITEMS    = 20;
   localparam int MAX_BURST     = 18;
   // layout code 3 has no enum member; bit 1 alone selects multichannel
   localparam logic [LAYOUT_W-1:0] LAYOUT_MULTI_ALT = 2'd3;

   // one rsp transaction as the scoreboard sees it
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } chan_word_type;

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_mix_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [WORD_W-1:0]          rsp_out_word;
   logic                       rsp_run_last;

   pcm_channel_formatter_unit #(
      .MaxChannels (MAX_CH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mix_sample   (req_mix_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_run_last     (rsp_run_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Formatter model: shadow config, gather state, expected word queue
   // ------------------------------------------------------------------
   logic                       cfg_hifi;
   logic [LAYOUT_W-1:0]        cfg_layout;
   logic [CHANNEL_COUNT_W-1:0] cfg_count;
   logic [OFFSET_W-1:0]        cfg_offset;
   logic [WORD_W-1:0]          gather_words [MAX_CH];
   int unsigned                gather_slot;
   logic [WORD_W-1:0]          held_left;

   chan_word_type expected_words [$];

   logic        req_gaps_on    = 1'b1;
   logic        rsp_stall_on   = 1'b1;
   int unsigned mismatch_total = 0;
   int unsigned items_sent     = 0;
   int unsigned words_seen     = 0;
   int unsigned configs_done   = 0;

   function automatic void reset_model();
      cfg_hifi    = 1'b0;
      cfg_layout  = LAYOUT_RESET;
      cfg_count   = CHANNEL_COUNT_RESET;
      cfg_offset  = '0;
      gather_slot = 0;
      held_left   = '0;
      foreach (gather_words[i]) gather_words[i] = '0;
   endfunction

   // count 0 acts as 1, anything past the frame width saturates
   function automatic int unsigned active_channels();
      int unsigned n;
      n = 32'(cfg_count);
      if (n == 0) n = 1;
      if (n > MAX_CH) n = MAX_CH;
      return n;
   endfunction

   // samples needed before a frame or pair comes out
   function automatic int unsigned items_per_frame();
      if (cfg_layout[1]) return active_channels();
      if (cfg_layout == LAYOUT_MONO) return 1;
      return 2;
   endfunction

   function automatic void apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_HIFI_MODE: cfg_hifi = d[0];
         CSR_LAYOUT: begin
            cfg_layout  = d[LAYOUT_W-1:0];
            gather_slot = 0;
         end
         CSR_CHANNEL_COUNT: begin
            cfg_count   = d;
            gather_slot = 0;
         end
         CSR_CHANNEL_OFFSET: cfg_offset = d[OFFSET_W-1:0];
         default: ;
      endcase
   endfunction

   // L,R pair, or a zero frame with the pair at the clamped offset
   function automatic void queue_pair(logic [WORD_W-1:0] l, logic [WORD_W-1:0] r);
      int unsigned n;
      int unsigned off;
      logic [WORD_W-1:0] w;
      n = active_channels();
      if (n <= 2) begin
         expected_words.push_back(chan_word_type'{l, 1'b0});
         expected_words.push_back(chan_word_type'{r, 1'b1});
         return;
      end
      off = 32'(cfg_offset);
      if (off > n - 2) off = n - 2;
      for (int unsigned c = 0; c < n; c++) begin
         w = '0;
         if (c == off) w = l;
         else if (c == off + 1) w = r;
         expected_words.push_back(chan_word_type'{w, c == n - 1});
      end
   endfunction

   function automatic void predict_sample(logic [SAMPLE_W-1:0] raw);
      logic [WORD_W-1:0] kept;
      logic [WORD_W-1:0] w;
      int unsigned n;
      int unsigned src;
      kept = cfg_hifi ? raw[31:16] : raw[15:0];
      w    = {kept[7:0], kept[15:8]};
      n    = active_channels();
      if (cfg_layout[1]) begin
         if (gather_slot >= n) gather_slot = 0;
         gather_words[gather_slot] = w;
         gather_slot++;
         if (gather_slot < n) return;
         gather_slot = 0;
         for (int unsigned c = 0; c < n; c++) begin
            src = c;
            if (n >= USB_ORDER_LEN && c < USB_ORDER_LEN) src = 32'(USB_ORDER[c]);
            expected_words.push_back(chan_word_type'{gather_words[src], c == n - 1});
         end
      end else if (cfg_layout == LAYOUT_MONO) begin
         if (n < 2) expected_words.push_back(chan_word_type'{w, 1'b1});
         else queue_pair(w, w);
      end else begin
         if (gather_slot[0] == 1'b0) begin
            held_left   = w;
            gather_slot = 1;
         end else begin
            gather_slot = 0;
            queue_pair(held_left, w);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // rsp side: random stall bursts, and the scoreboard
   // ------------------------------------------------------------------
   // one assignment per burst, so rsp_stall never gets two updates in a step
   always begin
      rsp_stall <= rsp_stall_on && ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
   end

   always @(posedge clock) begin
      chan_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected rsp transaction: out_word %h run_last %b",
                   rsp_out_word, rsp_run_last);
            mismatch_total++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_out_word !== exp_w.word) begin
               $error("out_word mismatch: expected %h, got %h", exp_w.word, rsp_out_word);
               mismatch_total++;
            end
            if (rsp_run_last !== exp_w.last) begin
               $error("run_last mismatch: expected %b, got %b", exp_w.last, rsp_run_last);
               mismatch_total++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // req side and config helpers
   // ------------------------------------------------------------------
   // Leaves req_valid high on return so back-to-back samples stream;
   // wait_for_results drops it once a batch is done.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mix_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sample(s);
      items_sent++;
   endtask

   // called in the step of the last acceptance, so the valid drop is clean
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      // a sample that only gathers has no word to wait for; give it time
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all four registers, back to back, only once the block is idle
   task automatic set_config(input logic [CSR_DATA_W-1:0] hifi,
                             input logic [CSR_DATA_W-1:0] lay,
                             input logic [CSR_DATA_W-1:0] cnt,
                             input logic [CSR_DATA_W-1:0] off);
      csr_index_type         order [4];
      logic [CSR_DATA_W-1:0] vals  [4];
      order = '{CSR_HIFI_MODE, CSR_LAYOUT, CSR_CHANNEL_COUNT, CSR_CHANNEL_OFFSET};
      vals  = '{hifi, lay, cnt, off};
      wait_for_results();
      csr_write_enable <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index      <= order[i];
         csr_write_data <= vals[i];
         @(posedge clock);
         apply_csr(order[i], vals[i]);
      end
      csr_write_enable <= 1'b0;
      configs_done++;
   endtask

   // full 4-bit data on every register; counts lean to the edges
   task automatic random_config();
      logic [CSR_DATA_W-1:0] cnt;
      case ($urandom_range(0, 5))
         0:       cnt = 4'd0;
         1:       cnt = 4'd1;
         2:       cnt = 4'd8;
         3:       cnt = 4'd15;
         4:       cnt = CSR_DATA_W'($urandom_range(2, 4));
         default: cnt = CSR_DATA_W'($urandom_range(0, 15));
      endcase
      set_config(CSR_DATA_W'($urandom_range(0, 15)), CSR_DATA_W'($urandom_range(0, 15)),
                 cnt, CSR_DATA_W'($urandom_range(0, 15)));
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return {16'h8000, 16'h7FFF};
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // stereo, two channels, 16-bit out of reset
   task automatic test_reset_defaults();
      send_sample(32'h1234_5678);
      send_sample(32'h8000_FFFF);
      wait_for_results();
   endtask

   // single word, count zero as one, L,R copy, wide frame with offset clamp
   task automatic test_mono_fanout();
      set_config(4'd0, CSR_DATA_W'(LAYOUT_MONO), 4'd1, 4'd0);
      send_sample(32'h0000_A5C3);
      set_config(4'd0, CSR_DATA_W'(LAYOUT_MONO), 4'd0, 4'd0);
      send_sample(32'h7FFF_8000);
      set_config(4'd1, CSR_DATA_W'(LAYOUT_MONO), 4'd2, 4'd0);
      send_sample(32'h7FFF_FFFF);
      set_config(4'd1, CSR_DATA_W'(LAYOUT_MONO), 4'd6, 4'd7);
      send_sample(32'h8000_0001);
   endtask

   // pair placement, saturated count, and a half pair dropped by a rewrite
   task automatic test_stereo_placement();
      set_config(4'd0, CSR_DATA_W'(LAYOUT_STEREO), 4'd8, 4'd3);
      send_sample(32'h0000_1122);
      send_sample(32'h0000_3344);
      set_config(4'd15, CSR_DATA_W'(LAYOUT_STEREO), 4'd15, 4'd15);
      send_sample(32'h5566_0000);
      send_sample(32'h7788_FFFF);
      set_config(4'd0, CSR_DATA_W'(LAYOUT_STEREO), 4'd1, 4'd0);
      send_sample(32'h0000_DEAD);
      set_config(4'd0, CSR_DATA_W'(LAYOUT_STEREO), 4'd1, 4'd0);
      send_sample(32'h0000_BEEF);
      send_sample(32'h0000_CAFE);
   endtask

   // 8-wide frame in USB order, then layout code 3 with a 3-wide frame
   task automatic test_multichannel_frames();
      set_config(4'd0, CSR_DATA_W'(LAYOUT_MULTI), 4'd8, 4'd0);
      for (int i = 0; i < 8; i++) send_sample({16'hFFFF, 8'h10 + 8'(i), 8'hA0 + 8'(i)});
      set_config(4'd1, CSR_DATA_W'(LAYOUT_MULTI_ALT), 4'd3, 4'd5);
      for (int i = 0; i < 3; i++) send_sample({8'hC0 + 8'(i), 8'h0F, 16'h0000});
   endtask

   // mostly whole frames/pairs with random content, now and then a stray sample
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned target;
      int unsigned n;
      int unsigned grp;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         random_config();
         grp    = items_per_frame();
         target = $urandom_range(16, 36);
         n      = 0;
         while (n < target) begin
            repeat (grp) send_sample(pick_sample());
            n += grp;
         end
         if ($urandom_range(0, 4) == 0) begin
            send_sample(pick_sample());
            n++;
         end
         sent += n;
      end
   endtask

   // full rate on both sides to close out the run
   task automatic test_unstalled_tail();
      int unsigned n;
      int unsigned grp;
      wait_for_results();
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      // let any stall burst already running expire
      repeat (MAX_BURST) @(posedge clock);
      random_config();
      grp = items_per_frame();
      n   = 0;
      while (n < TAIL_ITEMS) begin
         repeat (grp) send_sample(pick_sample());
         n += grp;
      end
      wait_for_results();
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_mono_fanout();
      test_stereo_placement();
      test_multichannel_frames();
      test_random_traffic();
      test_unstalled_tail();
      $display("Run covered %0d samples and %0d output words across %0d register settings.",
               items_sent, words_seen, configs_done);
      if (mismatch_total == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/pcf_pkg.sv
rtl/core/pcf_queue.sv
rtl/core/pcf_front.sv
rtl/core/pcf_back.sv
rtl/core/pcm_channel_formatter_unit.sv
tb/sv/pcm_channel_formatter_unit_tb.sv
